// File: hw/rtl/stac_pkg.sv
package stac_pkg;

    localparam int MaxStates    = 16;
    localparam int SectPerState = 8;
    localparam int CallSlots    = 16;
    localparam int DataSlots    = 16;
    localparam int AddrBits     = 32;
    localparam int StateBits    = 4;
    localparam int SectBits     = 3;
    localparam int SlotBits     = 4;
    localparam int CopyBits     = 13;
    localparam int CfgBits      = 5;
    localparam logic [CopyBits-1:0] MaxCopy = 13'd4096;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_SECT  = 2'd1,
        OP_CALL  = 2'd2,
        OP_DATA  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic                 ret_hit;
        logic                 sect_hit;
        logic [2:0]           sect_flags;
        logic                 call_hit;
        logic                 data_hit;
        logic [StateBits-1:0] tr_to;
        logic [CopyBits-1:0]  tr_copy;
        logic [StateBits-1:0] ret_state;
        logic [CopyBits-1:0]  ret_copy;
        logic                 exec;
    } t_status;

    typedef struct packed {
        logic                 load;
        logic                 ret_test;
        logic                 ret_clear;
        logic                 sect_step;
        logic                 sect_clr;
        logic                 sect_use_next;
        logic                 call_step;
        logic                 data_step;
        logic                 slot_clr;
        logic                 call_record;
        logic                 commit;
        logic [SlotBits-1:0]  idx;
    } t_cmd;

    function automatic logic [CopyBits-1:0] sat_copy(input logic [CopyBits-1:0] v);
        return (v > MaxCopy) ? MaxCopy : v;
    endfunction

endpackage

// File: hw/rtl/stac_datapath.sv
module stac_datapath
    import stac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [CfgBits-1:0]   i_state_count,
    input  logic [1:0]           i_opcode,
    input  logic [AddrBits-1:0]  i_access_addr,
    input  logic [2:0]           i_access_mask,
    input  logic [AddrBits-1:0]  i_link_addr,
    input  logic [SlotBits-1:0]  i_slot,
    input  logic [StateBits-1:0] i_from_state,
    input  logic [StateBits-1:0] i_to_state,
    input  logic [AddrBits-1:0]  i_entry_base,
    input  logic [AddrBits-1:0]  i_entry_size,
    input  logic [2:0]           i_entry_flags,
    input  logic [CopyBits-1:0]  i_param_bytes,
    input  logic [CopyBits-1:0]  i_return_bytes,
    output t_status              o_status,
    output logic [StateBits-1:0] o_cur_state
);

    localparam int SectIdx = StateBits + SectBits;
    localparam int SectDepth = MaxStates * SectPerState;

    logic [AddrBits-1:0]  r_addr, r_lr, r_base, r_size;
    logic [2:0]           r_mask, r_flags;
    logic [1:0]           r_op;
    logic [SlotBits-1:0]  r_slot;
    logic [StateBits-1:0] r_from, r_to;
    logic [CopyBits-1:0]  r_pb, r_rb;

    logic [StateBits-1:0] r_cur;

    logic [AddrBits-1:0]  r_ret_addr  [MaxStates];
    logic [CopyBits-1:0]  r_ret_bytes [MaxStates];
    logic [StateBits:0]   r_ret_state [MaxStates];

    logic [AddrBits-1:0]  r_sect_base  [SectDepth];
    logic [AddrBits-1:0]  r_sect_size  [SectDepth];
    logic [2:0]           r_sect_flags [SectDepth];
    logic                 r_sect_v     [SectDepth];
    logic [AddrBits-1:0]  r_rd_base, r_rd_size;
    logic [2:0]           r_rd_flags;
    logic                 r_rd_ok;

    logic                 r_call_v  [CallSlots];
    logic [StateBits-1:0] r_call_from [CallSlots];
    logic [StateBits-1:0] r_call_to   [CallSlots];
    logic [AddrBits-1:0]  r_call_ent  [CallSlots];
    logic [CopyBits-1:0]  r_call_pb   [CallSlots];
    logic [CopyBits-1:0]  r_call_rb   [CallSlots];

    logic [StateBits-1:0] r_data_from [DataSlots];
    logic [StateBits-1:0] r_data_to   [DataSlots];
    logic [AddrBits-1:0]  r_data_base [DataSlots];
    logic [AddrBits-1:0]  r_data_size [DataSlots];
    logic [2:0]           r_data_flags[DataSlots];

    t_status r_st;
    t_status st_load;

    logic [CfgBits-1:0]   lim;
    logic [StateBits-1:0] sect_state;
    logic [SectIdx-1:0]   rd_idx;
    logic [AddrBits:0]    end_s, end_d;
    logic                 in_s, in_d;
    logic [AddrBits-1:0]  clr_low;
    logic [StateBits-1:0] ct, dt;
    logic [StateBits:0]   rs;

    assign clr_low = {{(AddrBits-1){1'b1}}, 1'b0};
    assign lim = (i_state_count > CfgBits'(MaxStates)) ? CfgBits'(MaxStates) : i_state_count;
    assign sect_state = i_cmd.sect_use_next ? r_st.tr_to : r_cur;
    assign rd_idx = {sect_state, i_cmd.idx[SectBits-1:0]};

    assign end_s = {1'b0, r_rd_base} + {1'b0, r_rd_size};
    assign in_s = (r_addr >= r_rd_base) &&
                  (end_s[AddrBits] || ({1'b0, r_addr} <= end_s));
    assign ct = r_call_to[i_cmd.idx];
    assign dt = r_data_to[i_cmd.idx];
    assign end_d = {1'b0, r_data_base[i_cmd.idx]} + {1'b0, r_data_size[i_cmd.idx]};
    assign in_d = (r_addr >= r_data_base[i_cmd.idx]) &&
                  (end_d[AddrBits] || ({1'b0, r_addr} <= end_d));
    assign rs = r_ret_state[r_cur];

    always_comb begin
        st_load = '0;
        st_load.exec = i_access_mask[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode; r_addr <= i_access_addr; r_mask <= i_access_mask;
            r_lr <= i_link_addr; r_slot <= i_slot; r_from <= i_from_state;
            r_to <= i_to_state; r_base <= i_entry_base; r_size <= i_entry_size;
            r_flags <= i_entry_flags;
            r_pb <= sat_copy(i_param_bytes); r_rb <= sat_copy(i_return_bytes);
        end
        r_rd_base  <= r_sect_base[rd_idx];
        r_rd_size  <= r_sect_size[rd_idx];
        r_rd_flags <= r_sect_v[rd_idx] ? r_sect_flags[rd_idx] : 3'd0;
        r_rd_ok    <= i_cmd.sect_step;
        if (i_cmd.commit && r_op == OP_SECT && {1'b0, r_slot} < (SlotBits+1)'(SectPerState)) begin
            r_sect_base[{r_from, r_slot[SectBits-1:0]}]  <= r_base;
            r_sect_size[{r_from, r_slot[SectBits-1:0]}]  <= r_size;
            r_sect_flags[{r_from, r_slot[SectBits-1:0]}] <= r_flags;
        end
        if (i_cmd.commit && r_op == OP_CALL) begin
            r_call_from[r_slot] <= r_from; r_call_to[r_slot] <= r_to;
            r_call_ent[r_slot] <= r_base; r_call_pb[r_slot] <= r_pb;
            r_call_rb[r_slot] <= r_rb;
        end
        if (i_cmd.commit && r_op == OP_DATA) begin
            r_data_from[r_slot] <= r_from; r_data_to[r_slot] <= r_to;
            r_data_base[r_slot] <= r_base; r_data_size[r_slot] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_st  <= '0;
            for (int k = 0; k < MaxStates; k++) begin
                r_ret_addr[k] <= '0; r_ret_bytes[k] <= '0; r_ret_state[k] <= '1;
            end
            for (int k = 0; k < SectDepth; k++) r_sect_v[k] <= 1'b0;
            for (int k = 0; k < CallSlots; k++) r_call_v[k] <= 1'b0;
            for (int k = 0; k < DataSlots; k++) r_data_flags[k] <= '0;
        end else begin
            if (i_cmd.commit) begin
                unique case (t_opcode'(r_op))
                    OP_SECT: if ({1'b0, r_slot} < (SlotBits+1)'(SectPerState))
                        r_sect_v[{r_from, r_slot[SectBits-1:0]}] <= 1'b1;
                    OP_CALL: r_call_v[r_slot] <= 1'b1;
                    OP_DATA: r_data_flags[r_slot] <= r_flags;
                    OP_CHECK: if (r_st.sect_hit && (r_st.ret_hit || r_st.call_hit ||
                                                    r_st.data_hit))
                        r_cur <= r_st.tr_to;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_st <= st_load;
            end
            if (i_cmd.sect_clr) begin
                r_st.sect_hit <= 1'b0;
                r_st.sect_flags <= '0;
            end
            if (i_cmd.ret_test && r_mask[2] && !rs[StateBits] &&
                r_addr == (r_ret_addr[r_cur] & clr_low) && {1'b0, rs} < {1'b0, lim}) begin
                r_st.ret_hit <= 1'b1;
                r_st.tr_to   <= rs[StateBits-1:0];
                r_st.tr_copy <= r_ret_bytes[r_cur];
            end
            if (i_cmd.ret_clear) begin
                r_ret_addr[r_cur] <= '0; r_ret_bytes[r_cur] <= '0; r_ret_state[r_cur] <= '1;
            end
            if (r_rd_ok && !r_st.sect_hit && (r_rd_flags & r_mask) != 3'd0 && in_s) begin
                r_st.sect_hit <= 1'b1;
                r_st.sect_flags <= r_rd_flags;
            end
            if (i_cmd.call_step && !r_st.call_hit && r_call_v[i_cmd.idx] &&
                r_call_from[i_cmd.idx] == r_cur && {1'b0, ct} < lim &&
                (r_call_ent[i_cmd.idx] & clr_low) == r_addr && r_ret_addr[ct] == '0) begin
                r_st.call_hit <= 1'b1;
                r_st.tr_to    <= ct;
                r_st.tr_copy  <= r_call_pb[i_cmd.idx];
                r_ret_addr[ct]  <= r_lr & clr_low;
                r_ret_bytes[ct] <= r_call_rb[i_cmd.idx];
                r_ret_state[ct] <= {1'b0, r_cur};
            end
            if (i_cmd.data_step && !r_st.data_hit && r_data_from[i_cmd.idx] == r_cur &&
                {1'b0, dt} < lim && (r_data_flags[i_cmd.idx] & r_mask) != 3'd0 && in_d) begin
                r_st.data_hit <= 1'b1;
                r_st.tr_to    <= dt;
                r_st.tr_copy  <= '0;
            end
        end
    end

    always_comb begin
        o_status = r_st;
        o_status.ret_state = rs[StateBits-1:0];
        o_status.ret_copy  = r_ret_bytes[r_cur];
    end
    assign o_cur_state = r_cur;

endmodule

// File: hw/rtl/stac_ctrl.sv
module stac_ctrl
    import stac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  t_status              i_status,
    output t_cmd                 o_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_allowed,
    output logic                 o_took_transition,
    output logic [StateBits-1:0] o_entered_state,
    output logic [2:0]           o_granted_flags,
    output logic [CopyBits-1:0]  o_copy_bytes
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RET, S_SECT, S_SECT_WAIT, S_SECT_CHK, S_XFER, S_XFER2,
        S_TSECT, S_TSECT_WAIT, S_DONE
    } t_state;

    t_state               r_state;
    logic [SlotBits:0]    r_cnt;
    logic                 r_check;
    logic                 r_out_v, r_alw, r_tt;
    logic [StateBits-1:0] r_ns;
    logic [2:0]           r_gf;
    logic [CopyBits-1:0]  r_cb;
    logic                 via;

    assign via = i_status.ret_hit || i_status.call_hit || i_status.data_hit;
    assign o_in_ready = (r_state == S_IDLE) && !r_out_v;

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_cnt[SlotBits-1:0];
        o_cmd.load = i_in_valid && o_in_ready;
        unique case (r_state)
            S_RET:        o_cmd.ret_test = 1'b1;
            S_SECT:       o_cmd.sect_step = 1'b1;
            S_XFER:       begin
                o_cmd.call_step = i_status.exec;
                o_cmd.data_step = !i_status.exec;
            end
            S_XFER2:      o_cmd.sect_clr = 1'b1;
            S_TSECT:      begin
                o_cmd.sect_step = 1'b1;
                o_cmd.sect_use_next = 1'b1;
            end
            S_DONE:       begin
                o_cmd.commit = 1'b1;
                o_cmd.ret_clear = i_status.ret_hit;
            end
            S_LOAD:       o_cmd.commit = !r_check;
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_check <= 1'b0;
            r_out_v <= 1'b0;
            r_alw <= 1'b0; r_tt <= 1'b0; r_ns <= '0; r_gf <= '0; r_cb <= '0;
        end else begin
            if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_cmd.load) begin
                    r_check <= (i_opcode == OP_CHECK);
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt <= '0;
                    if (r_check) r_state <= S_RET;
                    else begin
                        r_alw <= 1'b0; r_tt <= 1'b0; r_ns <= '0; r_gf <= '0; r_cb <= '0;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RET: r_state <= S_SECT;
                S_SECT: begin
                    if (r_cnt == (SlotBits+1)'(SectPerState - 1)) r_state <= S_SECT_WAIT;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_SECT_WAIT: r_state <= S_SECT_CHK;
                S_SECT_CHK: begin
                    r_cnt <= '0;
                    priority if (i_status.ret_hit) r_state <= S_XFER2;
                    else if (i_status.sect_hit) r_state <= S_DONE;
                    else r_state <= S_XFER;
                end
                S_XFER: begin
                    if (r_cnt == (SlotBits+1)'(CallSlots - 1)) r_state <= S_XFER2;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_XFER2: begin
                    r_cnt <= '0;
                    r_state <= via ? S_TSECT : S_DONE;
                end
                S_TSECT: begin
                    if (r_cnt == (SlotBits+1)'(SectPerState - 1)) r_state <= S_TSECT_WAIT;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_TSECT_WAIT: r_state <= S_DONE;
                S_DONE: begin
                    r_alw <= i_status.sect_hit;
                    r_gf  <= i_status.sect_hit ? i_status.sect_flags : 3'd0;
                    r_tt  <= i_status.sect_hit && via;
                    r_ns  <= (i_status.sect_hit && via) ? i_status.tr_to : '0;
                    r_cb  <= (i_status.sect_hit && via) ? i_status.tr_copy : '0;
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_allowed = r_alw;
    assign o_took_transition = r_tt;
    assign o_entered_state = r_ns;
    assign o_granted_flags = r_gf;
    assign o_copy_bytes = r_cb;

endmodule

// File: hw/rtl/state_transition_access_checker.sv
// state transition access checker
// one input channel (i_in_valid/o_in_ready) carries a beat that is either a table
// load (section, call or data transition) or an access check; every beat gives
// exactly one result beat on o_out_valid/i_out_ready
// a load is committed and its result registered in S_LOAD; a check walks the
// pending return record, the 8 section slots of the current state, the 16
// transition slots (call slots for an exec access, else data slots) and the 8
// section slots of the target state; a return hit skips the transition slots,
// else a section hit in the current state ends the walk; the target state is
// walked only after a return, call or data hit, and the section table has one
// read port, so its slots are read one at a time; one beat is in flight at a
// time, and the next can be taken the cycle after the result is taken
// a granted transition moves the current state inside the block
// the state count is to be written through i_cfg_we/i_cfg_wdata only while
// idle; the block itself does not enforce this
// reset: current state 0, all tables empty, return records clear, state count 1
// a stalled receiver holds the result register and the input stays not ready
module state_transition_access_checker
    import stac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgBits-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [AddrBits-1:0]  i_access_addr,
    input  logic [2:0]           i_access_mask,
    input  logic [AddrBits-1:0]  i_link_addr,
    input  logic [SlotBits-1:0]  i_slot,
    input  logic [StateBits-1:0] i_from_state,
    input  logic [StateBits-1:0] i_to_state,
    input  logic [AddrBits-1:0]  i_entry_base,
    input  logic [AddrBits-1:0]  i_entry_size,
    input  logic [2:0]           i_entry_flags,
    input  logic [CopyBits-1:0]  i_param_bytes,
    input  logic [CopyBits-1:0]  i_return_bytes,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_allowed,
    output logic                 o_took_transition,
    output logic [StateBits-1:0] o_entered_state,
    output logic [2:0]           o_granted_flags,
    output logic [CopyBits-1:0]  o_copy_bytes
);

    logic [CfgBits-1:0]   r_state_count;
    t_cmd                 cmd;
    t_status              status;
    logic [StateBits-1:0] cur_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state_count <= CfgBits'(1);
        else if (i_cfg_we) r_state_count <= i_cfg_wdata;
    end

    stac_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_opcode,
        .i_status(status), .o_cmd(cmd), .o_out_valid, .i_out_ready,
        .o_allowed, .o_took_transition, .o_entered_state, .o_granted_flags, .o_copy_bytes
    );

    stac_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_state_count(r_state_count),
        .i_opcode, .i_access_addr, .i_access_mask, .i_link_addr, .i_slot,
        .i_from_state, .i_to_state, .i_entry_base, .i_entry_size, .i_entry_flags,
        .i_param_bytes, .i_return_bytes, .o_status(status), .o_cur_state(cur_state)
    );

    a_tt_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_took_transition |-> o_allowed)
        else $error("transition without grant");

    a_state_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_took_transition |-> cur_state == o_entered_state)
        else $error("state not moved");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_allowed))
        else $error("result dropped");

endmodule
